FILE: rtl/emt_pkg.sv
// Shared types and constants for the expiring message table.
package emt_pkg;

  localparam int MSG_W  = 16;
  localparam int TIME_W = 32;
  localparam int HOLD_W = 8;
  localparam int LIM_W  = 18;
  localparam int ACT_W  = 2;
  localparam int SLOT_W = 4;
  localparam int OUT_CNT_W = 4;

  localparam logic [LIM_W-1:0] MS_PER_SECOND = LIM_W'(1000);
  localparam logic [HOLD_W-1:0] HOLD_RESET   = HOLD_W'(5);

  localparam logic [ACT_W-1:0] ACT_POST  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

  typedef struct packed {
    logic [MSG_W-1:0]  msg;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic match;
    logic expired;
  } slot_cmp_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_FINISH = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

endpackage

FILE: rtl/emt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module emt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 10
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/emt_slot_unit.sv
// Shared per-slot compare unit: id match and elapsed-time expiry test.
module emt_slot_unit (
  input  emt_pkg::entry_t                   entry,
  input  logic [emt_pkg::MSG_W-1:0]         key_id,
  input  logic [emt_pkg::TIME_W-1:0]        now,
  input  logic [emt_pkg::LIM_W-1:0]         limit,
  output emt_pkg::slot_cmp_t                cmp
);

  logic [emt_pkg::TIME_W-1:0] elapsed;

  // Elapsed time wraps modulo 2^32.
  assign elapsed     = now - entry.stamp;
  assign cmp.match   = (entry.msg == key_id);
  assign cmp.expired = (elapsed > emt_pkg::TIME_W'(limit));

endmodule

FILE: rtl/expiring_message_table_core.sv
// Top level of the expiring message table: sequencer, entry RAM and counters.
// Sequence: post or tick: scan, finish, respond; read of an occupied slot: RAM wait,
//   respond; clear, any other read or a post of id zero: respond only.
// Throughput: one item at a time; busy stays high until the done cycle ends.
// Reset: synchronous, empties the table, stops the timer, hold_seconds = 5.
// The result is shown for exactly one cycle with done; the receiver cannot stall.
module expiring_message_table_core #(
  parameter int TABLE_SLOTS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [emt_pkg::ACT_W-1:0]      action,
  input  logic [emt_pkg::MSG_W-1:0]      message_id,
  input  logic [emt_pkg::TIME_W-1:0]     now_ms,
  input  logic [emt_pkg::SLOT_W-1:0]     slot_index,
  // configuration: hold_seconds
  input  logic                           hold_we,
  input  logic [emt_pkg::HOLD_W-1:0]     hold_data,
  // result channel
  output logic                           done,
  output logic [emt_pkg::OUT_CNT_W-1:0]  active_count,
  output logic                           timer_running,
  output logic                           post_dropped,
  output logic                           read_valid,
  output logic [emt_pkg::MSG_W-1:0]      read_message
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);

  emt_pkg::state_t state;

  // Control state
  logic [emt_pkg::HOLD_W-1:0] hold_seconds;
  logic [CNT_W-1:0]           count;        // table is always packed: slots 0..count-1
  logic                       tick_en;
  logic [CNT_W-1:0]           rd_idx;       // next slot to read during a scan
  logic                       ev_vld;       // RAM data of slot ev_idx is present
  logic [IDX_W-1:0]           ev_idx;
  logic [CNT_W-1:0]           wr_ptr;       // compaction write pointer for a tick
  logic                       found;

  // Latched item payload
  logic [emt_pkg::ACT_W-1:0]  lat_act;
  logic [emt_pkg::MSG_W-1:0]  lat_id;
  logic [emt_pkg::TIME_W-1:0] lat_now;
  logic [emt_pkg::LIM_W-1:0]  lim;

  // Result payload
  logic                       rsp_drop;
  logic                       rsp_rvalid;
  logic [emt_pkg::MSG_W-1:0]  rsp_rmsg;

  // RAM ports
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  emt_pkg::entry_t            ram_wdata;
  logic [IDX_W-1:0]           ram_raddr;
  logic [emt_pkg::ENTRY_W-1:0] ram_rdata;
  emt_pkg::entry_t            rd_entry;
  emt_pkg::slot_cmp_t         cmp;

  logic accept;
  logic issue;

  assign accept   = start && (state == emt_pkg::ST_IDLE);
  assign issue    = (rd_idx < count);
  assign rd_entry = emt_pkg::entry_t'(ram_rdata);

  emt_ram #(
    .WIDTH (emt_pkg::ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  emt_slot_unit u_unit (
    .entry  (rd_entry),
    .key_id (lat_id),
    .now    (lat_now),
    .limit  (lim),
    .cmp    (cmp)
  );

  // Read address: the requested slot while idle (read action), else the scan index.
  always_comb begin
    if (state == emt_pkg::ST_IDLE) begin
      ram_raddr = IDX_W'(slot_index);
    end else begin
      ram_raddr = rd_idx[IDX_W-1:0];
    end
  end

  // Write port: refresh a matching post, move a surviving entry, or append a post.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx;
    ram_wdata = rd_entry;
    case (state)
      emt_pkg::ST_SCAN: begin
        if (ev_vld) begin
          if (lat_act == emt_pkg::ACT_POST) begin
            ram_we          = cmp.match;
            ram_waddr       = ev_idx;
            ram_wdata.msg   = rd_entry.msg;
            ram_wdata.stamp = lat_now;
          end else begin
            ram_we    = !cmp.expired;
            ram_waddr = wr_ptr[IDX_W-1:0];
            ram_wdata = rd_entry;
          end
        end
      end
      emt_pkg::ST_FINISH: begin
        if ((lat_act == emt_pkg::ACT_POST) && !found && (count < SLOTS_CNT)) begin
          ram_we          = 1'b1;
          ram_waddr       = count[IDX_W-1:0];
          ram_wdata.msg   = lat_id;
          ram_wdata.stamp = lat_now;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= emt_pkg::ST_IDLE;
      hold_seconds <= emt_pkg::HOLD_RESET;
      count        <= '0;
      tick_en      <= 1'b0;
      rd_idx       <= '0;
      ev_vld       <= 1'b0;
      ev_idx       <= '0;
      wr_ptr       <= '0;
      found        <= 1'b0;
    end else begin
      if (hold_we) begin
        hold_seconds <= hold_data;
      end
      case (state)
        emt_pkg::ST_IDLE: begin
          rd_idx <= '0;
          ev_vld <= 1'b0;
          wr_ptr <= '0;
          found  <= 1'b0;
          if (accept) begin
            case (action)
              emt_pkg::ACT_POST: begin
                // A post of id zero is ignored outright.
                if (message_id == '0) begin
                  state <= emt_pkg::ST_RESP;
                end else begin
                  state <= emt_pkg::ST_SCAN;
                end
              end
              emt_pkg::ACT_TICK: begin
                state <= emt_pkg::ST_SCAN;
              end
              emt_pkg::ACT_CLEAR: begin
                count   <= '0;
                tick_en <= 1'b0;
                state   <= emt_pkg::ST_RESP;
              end
              emt_pkg::ACT_READ: begin
                if (32'(slot_index) < 32'(count)) begin
                  state <= emt_pkg::ST_RDWAIT;
                end else begin
                  state <= emt_pkg::ST_RESP;
                end
              end
              default: begin
                state <= emt_pkg::ST_RESP;
              end
            endcase
          end
        end
        emt_pkg::ST_SCAN: begin
          // Issue one slot read per cycle, evaluate the previous one.
          if (issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
            ev_idx <= rd_idx[IDX_W-1:0];
          end
          ev_vld <= issue;
          if (ev_vld) begin
            if (lat_act == emt_pkg::ACT_POST) begin
              if (cmp.match) begin
                found <= 1'b1;
              end
            end else if (!cmp.expired) begin
              wr_ptr <= wr_ptr + CNT_W'(1);
            end
          end
          if (!issue && !ev_vld) begin
            state <= emt_pkg::ST_FINISH;
          end
        end
        emt_pkg::ST_FINISH: begin
          if (lat_act == emt_pkg::ACT_POST) begin
            // Posting into an empty table starts the timer.
            if (count == '0) begin
              tick_en <= 1'b1;
            end
            if (!found && (count < SLOTS_CNT)) begin
              count <= count + CNT_W'(1);
            end
          end else begin
            // Drop expired entries; survivors are already packed.
            count <= wr_ptr;
            if (wr_ptr == '0) begin
              tick_en <= 1'b0;
            end
          end
          state <= emt_pkg::ST_RESP;
        end
        emt_pkg::ST_RDWAIT: begin
          state <= emt_pkg::ST_RESP;
        end
        emt_pkg::ST_RESP: begin
          state <= emt_pkg::ST_IDLE;
        end
        default: begin
          state <= emt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: latched item, expiry limit and result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      lat_act    <= action;
      lat_id     <= message_id;
      lat_now    <= now_ms;
      lim        <= emt_pkg::LIM_W'(hold_seconds) * emt_pkg::MS_PER_SECOND;
      rsp_drop   <= 1'b0;
      rsp_rvalid <= 1'b0;
      rsp_rmsg   <= '0;
    end
    if (state == emt_pkg::ST_FINISH) begin
      if ((lat_act == emt_pkg::ACT_POST) && !found && (count >= SLOTS_CNT)) begin
        rsp_drop <= 1'b1;
      end
    end
    if (state == emt_pkg::ST_RDWAIT) begin
      // Slots below the count always hold a nonzero id.
      rsp_rvalid <= 1'b1;
      rsp_rmsg   <= rd_entry.msg;
    end
  end

  assign busy          = (state != emt_pkg::ST_IDLE);
  assign done          = (state == emt_pkg::ST_RESP);
  assign active_count  = emt_pkg::OUT_CNT_W'(count);
  assign timer_running = tick_en;
  assign post_dropped  = rsp_drop;
  assign read_valid    = rsp_rvalid;
  assign read_message  = rsp_rmsg;

endmodule
